### hw/rtl/nnts_pkg.sv
// ----------------------------------------------------------------------------
// nnts_pkg
// Types and constants shared by the nearest-neighbor thumbnail scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package nnts_pkg;

  localparam int unsigned AddrW     = 5;
  localparam int unsigned DataW     = 32;
  localparam int unsigned SrcCfgW   = 13;
  localparam int unsigned ThumbCfgW = 9;
  localparam int unsigned ScaleW    = 29;
  localparam int unsigned FracW     = 16;
  localparam int unsigned PosW      = ScaleW - FracW;

  localparam logic [ScaleW-1:0]    OneQ16    = ScaleW'(32'h0001_0000);
  localparam logic [ScaleW-1:0]    AccMax    = {ScaleW{1'b1}};
  localparam logic [SrcCfgW-1:0]   SrcDimRst = SrcCfgW'(1);
  localparam logic [ThumbCfgW-1:0] ThDimRst  = ThumbCfgW'(1);

  typedef enum logic [2:0] {
    RegSrcWidth   = 3'd0,
    RegSrcHeight  = 3'd1,
    RegThumbWidth = 3'd2,
    RegThumbHeight = 3'd3,
    RegScale      = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [SrcCfgW-1:0]   source_width;
    logic [SrcCfgW-1:0]   source_height;
    logic [ThumbCfgW-1:0] thumb_width;
    logic [ThumbCfgW-1:0] thumb_height;
    logic [ScaleW-1:0]    scale_q16;
  } cfg_t;

  typedef struct packed {
    logic [7:0] src_red;
    logic [7:0] src_green;
    logic [7:0] src_blue;
  } in_pixel_t;

  typedef struct packed {
    logic [15:0] pixel_rgb565;
    logic [7:0]  out_col;
    logic [7:0]  out_row;
    logic        frame_done;
  } out_pixel_t;

  // saturating accumulator step
  function automatic logic [ScaleW-1:0] acc_add(input logic [ScaleW-1:0] acc,
                                                input logic [ScaleW-1:0] step);
    logic [ScaleW:0] sum;
    sum = {1'b0, acc} + {1'b0, step};
    return sum[ScaleW] ? AccMax : sum[ScaleW-1:0];
  endfunction

  function automatic logic [15:0] to_rgb565(input in_pixel_t pix);
    return {pix.src_red[7:3], pix.src_green[7:2], pix.src_blue[7:3]};
  endfunction

endpackage

`default_nettype wire

### hw/rtl/nnts_cfg_regs.sv
// ----------------------------------------------------------------------------
// nnts_cfg_regs
// APB register file holding image sizes and the Q13.16 scale step.
// ----------------------------------------------------------------------------
`default_nettype none

module nnts_cfg_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [nnts_pkg::AddrW-1:0]  paddr,
  input  wire logic [nnts_pkg::DataW-1:0]  pwdata,
  output logic      [nnts_pkg::DataW-1:0]  prdata,
  output logic                             pready,
  output nnts_pkg::cfg_t                   cfg_o
);

  nnts_pkg::cfg_t     cfg_q;
  nnts_pkg::reg_idx_e idx;
  logic               wr_en;

  assign idx    = nnts_pkg::reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.source_width  <= nnts_pkg::SrcDimRst;
      cfg_q.source_height <= nnts_pkg::SrcDimRst;
      cfg_q.thumb_width   <= nnts_pkg::ThDimRst;
      cfg_q.thumb_height  <= nnts_pkg::ThDimRst;
      cfg_q.scale_q16     <= nnts_pkg::OneQ16;
    end else if (wr_en) begin
      unique case (idx)
        nnts_pkg::RegSrcWidth:    cfg_q.source_width  <= pwdata[nnts_pkg::SrcCfgW-1:0];
        nnts_pkg::RegSrcHeight:   cfg_q.source_height <= pwdata[nnts_pkg::SrcCfgW-1:0];
        nnts_pkg::RegThumbWidth:  cfg_q.thumb_width   <= pwdata[nnts_pkg::ThumbCfgW-1:0];
        nnts_pkg::RegThumbHeight: cfg_q.thumb_height  <= pwdata[nnts_pkg::ThumbCfgW-1:0];
        nnts_pkg::RegScale:       cfg_q.scale_q16     <= pwdata[nnts_pkg::ScaleW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      nnts_pkg::RegSrcWidth:    prdata = nnts_pkg::DataW'(cfg_q.source_width);
      nnts_pkg::RegSrcHeight:   prdata = nnts_pkg::DataW'(cfg_q.source_height);
      nnts_pkg::RegThumbWidth:  prdata = nnts_pkg::DataW'(cfg_q.thumb_width);
      nnts_pkg::RegThumbHeight: prdata = nnts_pkg::DataW'(cfg_q.thumb_height);
      nnts_pkg::RegScale:       prdata = nnts_pkg::DataW'(cfg_q.scale_q16);
      default:                  prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/nearest_neighbor_thumb_scaler.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_thumb_scaler
// Nearest-neighbor downscaler: raster RGB888 source pixels in, RGB565
// thumbnail pixels with coordinates and end-of-frame flag out.
// Path: input register, counter and accumulator update, result register.
// Throughput: one source request per cycle unless thumb_ready_i holds a
// full result register; set by that single counter and accumulator update.
// Reset: counters and accumulators clear, registers go to 1,1,1,1 and 1.0.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_neighbor_thumb_scaler #(
  parameter int unsigned MAX_SOURCE_DIM = 4096,
  parameter int unsigned MAX_THUMB_DIM  = 256
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [nnts_pkg::AddrW-1:0]  paddr,
  input  wire logic [nnts_pkg::DataW-1:0]  pwdata,
  output logic      [nnts_pkg::DataW-1:0]  prdata,
  output logic                             pready,
  input  wire nnts_pkg::in_pixel_t         src_i,
  input  wire logic                        src_valid_i,
  output logic                             src_ready_o,
  output nnts_pkg::out_pixel_t             thumb_o,
  output logic                             thumb_valid_o,
  input  wire logic                        thumb_ready_i
);

  localparam int unsigned SrcIdxW = $clog2(MAX_SOURCE_DIM);
  localparam int unsigned SrcDimW = (SrcIdxW + 1 > nnts_pkg::SrcCfgW) ?
                                    SrcIdxW + 1 : nnts_pkg::SrcCfgW;
  localparam int unsigned ThCntW  = $clog2(MAX_THUMB_DIM) + 1;
  localparam int unsigned ThDimW  = (ThCntW > nnts_pkg::ThumbCfgW) ?
                                    ThCntW : nnts_pkg::ThumbCfgW;
  localparam int unsigned CmpW    = (SrcIdxW > nnts_pkg::PosW) ?
                                    SrcIdxW : nnts_pkg::PosW;
  localparam int unsigned ScW     = nnts_pkg::ScaleW;

  nnts_pkg::cfg_t cfg;

  nnts_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // effective sizes
  logic [SrcDimW-1:0] w_dim, h_dim;
  logic [ThDimW-1:0]  tw_dim, th_dim;
  logic [SrcIdxW-1:0] w_last, h_last;
  logic [ThCntW-1:0]  tw_lim, th_lim;
  logic [ScW-1:0]     step;

  always_comb begin
    w_dim = SrcDimW'(cfg.source_width);
    if (cfg.source_width == '0) begin
      w_dim = SrcDimW'(1);
    end else if (w_dim > SrcDimW'(MAX_SOURCE_DIM)) begin
      w_dim = SrcDimW'(MAX_SOURCE_DIM);
    end
    h_dim = SrcDimW'(cfg.source_height);
    if (cfg.source_height == '0) begin
      h_dim = SrcDimW'(1);
    end else if (h_dim > SrcDimW'(MAX_SOURCE_DIM)) begin
      h_dim = SrcDimW'(MAX_SOURCE_DIM);
    end
    tw_dim = ThDimW'(cfg.thumb_width);
    if (cfg.thumb_width == '0) begin
      tw_dim = ThDimW'(1);
    end else if (tw_dim > ThDimW'(MAX_THUMB_DIM)) begin
      tw_dim = ThDimW'(MAX_THUMB_DIM);
    end
    th_dim = ThDimW'(cfg.thumb_height);
    if (cfg.thumb_height == '0) begin
      th_dim = ThDimW'(1);
    end else if (th_dim > ThDimW'(MAX_THUMB_DIM)) begin
      th_dim = ThDimW'(MAX_THUMB_DIM);
    end
  end

  assign w_last = SrcIdxW'(w_dim - SrcDimW'(1));
  assign h_last = SrcIdxW'(h_dim - SrcDimW'(1));
  assign tw_lim = ThCntW'(tw_dim);
  assign th_lim = ThCntW'(th_dim);
  assign step   = (cfg.scale_q16 < nnts_pkg::OneQ16) ? nnts_pkg::OneQ16 : cfg.scale_q16;

  // input register and handshake
  logic                 s1_valid_q;
  nnts_pkg::in_pixel_t  s1_pix_q;
  logic                 out_valid_q;
  nnts_pkg::out_pixel_t out_q;
  logic                 out_free, s1_go, src_acc;

  assign out_free    = !out_valid_q || thumb_ready_i;
  assign s1_go       = s1_valid_q && out_free;
  assign src_ready_o = !s1_valid_q || s1_go;
  assign src_acc     = src_valid_i && src_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (src_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (src_acc) begin
      s1_pix_q <= src_i;
    end
  end

  // position state
  logic [SrcIdxW-1:0] src_col_q, src_row_q;
  logic [ThCntW-1:0]  th_col_q, th_row_q;
  logic [ScW-1:0]     col_acc_q, row_acc_q;

  logic [CmpW-1:0]   col_pos, row_pos, col_samp, row_samp;
  logic              row_end, last_src_row, frame_end;
  logic              row_active, hit, row_last, th_last_row;
  logic [ThCntW-1:0] next_col, next_row;

  always_comb begin
    col_pos  = CmpW'(col_acc_q[ScW-1:nnts_pkg::FracW]);
    row_pos  = CmpW'(row_acc_q[ScW-1:nnts_pkg::FracW]);
    col_samp = (col_pos > CmpW'(w_last)) ? CmpW'(w_last) : col_pos;
    row_samp = (row_pos > CmpW'(h_last)) ? CmpW'(h_last) : row_pos;
  end

  assign row_end      = src_col_q >= w_last;
  assign last_src_row = src_row_q >= h_last;
  assign frame_end    = row_end && last_src_row;
  assign row_active   = (th_row_q < th_lim) && (CmpW'(src_row_q) == row_samp);
  assign hit          = row_active && (th_col_q < tw_lim) && (CmpW'(src_col_q) == col_samp);
  assign next_col     = ThCntW'(th_col_q + ThCntW'(1));
  assign next_row     = ThCntW'(th_row_q + ThCntW'(1));
  assign row_last     = (next_col >= tw_lim) || row_end;
  assign th_last_row  = (next_row >= th_lim) || last_src_row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_col_q <= '0;
      src_row_q <= '0;
      th_col_q  <= '0;
      th_row_q  <= '0;
      col_acc_q <= '0;
      row_acc_q <= '0;
    end else if (s1_go) begin
      if (frame_end) begin
        src_col_q <= '0;
        src_row_q <= '0;
        th_col_q  <= '0;
        th_row_q  <= '0;
        col_acc_q <= '0;
        row_acc_q <= '0;
      end else if (row_end) begin
        src_col_q <= '0;
        src_row_q <= SrcIdxW'(src_row_q + SrcIdxW'(1));
        th_col_q  <= '0;
        col_acc_q <= '0;
        if (row_active) begin
          th_row_q  <= next_row;
          row_acc_q <= nnts_pkg::acc_add(row_acc_q, step);
        end
      end else begin
        src_col_q <= SrcIdxW'(src_col_q + SrcIdxW'(1));
        if (hit) begin
          th_col_q  <= next_col;
          col_acc_q <= nnts_pkg::acc_add(col_acc_q, step);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && hit) begin
      out_valid_q <= 1'b1;
    end else if (thumb_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && hit) begin
      out_q.pixel_rgb565 <= nnts_pkg::to_rgb565(s1_pix_q);
      out_q.out_col      <= th_col_q[7:0];
      out_q.out_row      <= th_row_q[7:0];
      out_q.frame_done   <= row_last && th_last_row;
    end
  end

  assign thumb_valid_o = out_valid_q;
  assign thumb_o       = out_q;

endmodule

`default_nettype wire
